>>> rtl/fagc_pkg.sv
// fagc_pkg: shared types, widths and constants of the frame gain scaler.
// No dependencies; every rtl file but fagc_ram refers to it by scoped names.
package fagc_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int GAIN_W    = 16;
	localparam int LEVEL_W   = 15;
	localparam int DIVR_W    = 7;
	localparam int HANG_W    = 8;
	localparam int SUM_W     = 22;
	localparam int NUM_W     = 27;
	localparam int DEN_W     = 16;
	localparam int CNT_W     = 5;
	localparam int GAIN_FRAC = 12;

	localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(NUM_W - 1);
	localparam logic [GAIN_W-1:0] UNITY     = GAIN_W'(1 << GAIN_FRAC);
	localparam logic [NUM_W-1:0]  SAFE_NUM  = NUM_W'(32767 << GAIN_FRAC);

	localparam logic [LEVEL_W-1:0] RST_TARGET  = LEVEL_W'(6000);
	localparam logic [LEVEL_W-1:0] RST_SILENCE = LEVEL_W'(200);
	localparam logic [GAIN_W-1:0]  RST_MIN     = GAIN_W'(1024);
	localparam logic [GAIN_W-1:0]  RST_MAX     = GAIN_W'(32768);
	localparam logic [DIVR_W-1:0]  RST_ATTACK  = DIVR_W'(4);
	localparam logic [DIVR_W-1:0]  RST_RELEASE = DIVR_W'(16);
	localparam logic [HANG_W-1:0]  RST_HANG    = HANG_W'(12);
	localparam logic [DIVR_W-1:0]  RST_WEIGHT  = DIVR_W'(8);
	localparam logic [GAIN_W-1:0]  RST_LEVEL   = GAIN_W'(6000);

	typedef enum logic [2:0] {
		REG_TARGET  = 3'd0,
		REG_SILENCE = 3'd1,
		REG_MIN     = 3'd2,
		REG_MAX     = 3'd3,
		REG_ATTACK  = 3'd4,
		REG_RELEASE = 3'd5,
		REG_HANG    = 3'd6,
		REG_WEIGHT  = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_LEVEL,
		OP_SMOOTH,
		OP_WANT,
		OP_STEP,
		OP_SAFE
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GO,
		ST_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic div_go;
		logic emit;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic frame_done;
		logic div_done;
		logic emit_last;
	} status_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] target_level;
		logic [LEVEL_W-1:0] silence_level;
		logic [GAIN_W-1:0]  min_gain;
		logic [GAIN_W-1:0]  max_gain;
		logic [DIVR_W-1:0]  attack_divisor;
		logic [DIVR_W-1:0]  release_divisor;
		logic [HANG_W-1:0]  hang_frames;
		logic [DIVR_W-1:0]  smoothing_weight;
	} cfg_t;

endpackage

>>> rtl/frame_agc_gain_scaler_core.sv
// frame_agc_gain_scaler_core: top level of the frame-based gain scaler.
// Depends on fagc_pkg, fagc_ctrl and fagc_dp (which holds fagc_ram and fagc_div).
//
// Usage:
//   Input: drive sample_in and frame_end_in with start high; a word is taken
//   at each rising edge where start is high and busy is low. Within a frame
//   one word per cycle is taken. The word with frame_end_in set, or the
//   MAX_FRAME-th word of a frame, closes the frame and raises busy.
//   Per frame: five divides on one shared radix-2 divider (level, smoothed
//   level, desired gain, gain step, clip-safe gain), then the n words are
//   read back from the frame RAM.
//   Output: result_valid marks each scaled word for one cycle; the first comes
//   after the five divides, through the RAM read register and the output
//   register, then one per cycle, frame_end_out on the last. The receiver
//   cannot stall; every word must be taken. busy drops once the last word
//   has been read from the frame RAM.
//   Configuration: APB writes at byte address 4*index, to be written only while
//   idle; the user must see to it, the block does not. Reset: sets the sequencer,
//   counters, gain state and registers to defaults; the RAM needs no clearing.
module frame_agc_gain_scaler_core #(
	parameter int MAX_FRAME = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command channel
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [fagc_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                 frame_end_in,
	// result channel
	output logic                                 result_valid,
	output logic signed [fagc_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                 frame_end_out,
	output logic [fagc_pkg::GAIN_W-1:0]          applied_gain,
	// configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [4:0]                           paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	fagc_pkg::cfg_t      cfg_q;
	fagc_pkg::cmd_t      cmd;
	fagc_pkg::status_t   status;
	fagc_pkg::reg_idx_t  reg_idx;
	logic                wr_en;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = fagc_pkg::reg_idx_t'(paddr[4:2]);

	// register file: hold defaults until written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_level     <= fagc_pkg::RST_TARGET;
			cfg_q.silence_level    <= fagc_pkg::RST_SILENCE;
			cfg_q.min_gain         <= fagc_pkg::RST_MIN;
			cfg_q.max_gain         <= fagc_pkg::RST_MAX;
			cfg_q.attack_divisor   <= fagc_pkg::RST_ATTACK;
			cfg_q.release_divisor  <= fagc_pkg::RST_RELEASE;
			cfg_q.hang_frames      <= fagc_pkg::RST_HANG;
			cfg_q.smoothing_weight <= fagc_pkg::RST_WEIGHT;
		end else if (wr_en) begin
			case (reg_idx)
				fagc_pkg::REG_TARGET:  cfg_q.target_level     <= pwdata[14:0];
				fagc_pkg::REG_SILENCE: cfg_q.silence_level    <= pwdata[14:0];
				fagc_pkg::REG_MIN:     cfg_q.min_gain         <= pwdata[15:0];
				fagc_pkg::REG_MAX:     cfg_q.max_gain         <= pwdata[15:0];
				fagc_pkg::REG_ATTACK:  cfg_q.attack_divisor   <= pwdata[6:0];
				fagc_pkg::REG_RELEASE: cfg_q.release_divisor  <= pwdata[6:0];
				fagc_pkg::REG_HANG:    cfg_q.hang_frames      <= pwdata[7:0];
				fagc_pkg::REG_WEIGHT:  cfg_q.smoothing_weight <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// read-back mux
	always_comb begin
		case (reg_idx)
			fagc_pkg::REG_TARGET:  prdata = 32'(cfg_q.target_level);
			fagc_pkg::REG_SILENCE: prdata = 32'(cfg_q.silence_level);
			fagc_pkg::REG_MIN:     prdata = 32'(cfg_q.min_gain);
			fagc_pkg::REG_MAX:     prdata = 32'(cfg_q.max_gain);
			fagc_pkg::REG_ATTACK:  prdata = 32'(cfg_q.attack_divisor);
			fagc_pkg::REG_RELEASE: prdata = 32'(cfg_q.release_divisor);
			fagc_pkg::REG_HANG:    prdata = 32'(cfg_q.hang_frames);
			fagc_pkg::REG_WEIGHT:  prdata = 32'(cfg_q.smoothing_weight);
			default:               prdata = '0;
		endcase
	end

	fagc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	fagc_dp #(.MAX_FRAME(MAX_FRAME)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg           (cfg_q),
		.sample_in     (sample_in),
		.frame_end_in  (frame_end_in),
		.result_valid  (result_valid),
		.sample_out    (sample_out),
		.frame_end_out (frame_end_out),
		.applied_gain  (applied_gain)
	);

endmodule

>>> rtl/fagc_ram.sv
// fagc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module fagc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/fagc_div.sv
// fagc_div: restoring divider, one quotient bit per cycle.
// Depends on fagc_pkg.
module fagc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fagc_pkg::NUM_W-1:0]    num,
	input  logic [fagc_pkg::DEN_W-1:0]    den,
	output logic                          busy,
	output logic                          done,
	output logic [fagc_pkg::NUM_W-1:0]    quo
);

	logic [fagc_pkg::NUM_W-1:0] quo_q;
	logic [fagc_pkg::DEN_W-1:0] rem_q;
	logic [fagc_pkg::DEN_W-1:0] den_q;
	logic [fagc_pkg::CNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [fagc_pkg::DEN_W:0]   rem_sh;
	logic                       ge;

	assign rem_sh = {rem_q, quo_q[fagc_pkg::NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == fagc_pkg::DIV_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? fagc_pkg::DEN_W'(rem_sh - {1'b0, den_q})
			            : rem_sh[fagc_pkg::DEN_W-1:0];
			quo_q <= {quo_q[fagc_pkg::NUM_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> rtl/fagc_dp.sv
// fagc_dp: frame buffer, level/gain registers, shared divider and scaling output stage.
// Depends on fagc_pkg, fagc_ram and fagc_div.
module fagc_dp #(
	parameter int MAX_FRAME = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fagc_pkg::cmd_t                       cmd,
	output fagc_pkg::status_t                    status,
	input  fagc_pkg::cfg_t                       cfg,
	input  logic signed [fagc_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                 frame_end_in,
	output logic                                 result_valid,
	output logic signed [fagc_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                 frame_end_out,
	output logic [fagc_pkg::GAIN_W-1:0]          applied_gain
);

	localparam int FW = $clog2(MAX_FRAME + 1);
	localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
	localparam int GW = fagc_pkg::GAIN_W;
	localparam int NW = fagc_pkg::NUM_W;
	localparam int PW = fagc_pkg::SAMPLE_W + GW + 1;

	logic [FW-1:0]                fill_q;
	logic [FW-1:0]                idx_q;
	logic [fagc_pkg::SUM_W-1:0]   sum_q;
	logic [GW-1:0]                peak_q;
	logic [GW-1:0]                level_q;
	logic [GW-1:0]                smooth_q;
	logic [fagc_pkg::HANG_W-1:0]  run_q;
	logic [GW-1:0]                want_q;
	logic [GW-1:0]                cur_q;
	logic [GW-1:0]                applied_q;

	logic [GW-1:0]                abs_in;
	logic [NW-1:0]                div_num;
	logic [fagc_pkg::DEN_W-1:0]   div_den;
	logic [NW-1:0]                quo;
	logic                         div_done;
	logic                         div_busy;
	logic [fagc_pkg::SAMPLE_W-1:0] rd_data;

	logic [GW-1:0]                bounded;
	logic [fagc_pkg::DIVR_W-1:0]  weight;
	logic [fagc_pkg::DIVR_W-1:0]  rate_div;
	logic [fagc_pkg::LEVEL_W:0]   eff;
	logic                         rising;
	logic [GW-1:0]                delta;
	logic                         hold_unity;
	logic [NW-1:0]                want_raw, want_lo;
	logic [NW-1:0]                step_a, step_b;
	logic [GW-1:0]                gain_new, gain_lo;
	logic [NW-1:0]                safe_hi, safe_lo;
	logic [GW-1:0]                app_a;

	logic                         valid_s1, last_s1;
	logic signed [PW-1:0]         prod;
	logic signed [PW-1:0]         scaled;

	assign abs_in  = sample_in[fagc_pkg::SAMPLE_W-1] ? GW'(-{sample_in[15], sample_in})
	                                                 : GW'(sample_in);
	assign bounded = (level_q == '0) ? GW'(1) : level_q;
	assign weight  = (cfg.smoothing_weight == '0) ? fagc_pkg::DIVR_W'(1) : cfg.smoothing_weight;
	assign eff     = ({1'b0, smooth_q[GW-2:0]} > GW'(cfg.silence_level) || smooth_q[GW-1])
	                 ? smooth_q : GW'(cfg.silence_level);
	assign rising  = want_q > cur_q;
	assign delta   = rising ? GW'(want_q - cur_q) : GW'(cur_q - want_q);
	assign rate_div = rising
		? ((cfg.attack_divisor == '0) ? fagc_pkg::DIVR_W'(1) : cfg.attack_divisor)
		: ((cfg.release_divisor == '0) ? fagc_pkg::DIVR_W'(1) : cfg.release_divisor);

	// operand select for the shared divider
	always_comb begin
		div_num = '0;
		div_den = '0;
		case (cmd.op)
			fagc_pkg::OP_LEVEL: begin
				div_num = NW'(sum_q);
				div_den = fagc_pkg::DEN_W'(fill_q);
			end
			fagc_pkg::OP_SMOOTH: begin
				div_num = NW'(smooth_q) * NW'(weight - 1'b1) + NW'(bounded) + NW'(weight >> 1);
				div_den = fagc_pkg::DEN_W'(weight);
			end
			fagc_pkg::OP_WANT: begin
				div_num = NW'({cfg.target_level, {fagc_pkg::GAIN_FRAC{1'b0}}});
				div_den = (eff == '0) ? fagc_pkg::DEN_W'(1) : fagc_pkg::DEN_W'(eff);
			end
			fagc_pkg::OP_STEP: begin
				div_num = NW'(delta) + NW'(rate_div) - NW'(1);
				div_den = fagc_pkg::DEN_W'(rate_div);
			end
			fagc_pkg::OP_SAFE: begin
				div_num = fagc_pkg::SAFE_NUM;
				div_den = peak_q;
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	// result shaping after each divide
	always_comb begin
		hold_unity = (level_q <= GW'(cfg.silence_level)) && (run_q >= cfg.hang_frames);
		want_raw   = hold_unity ? NW'(fagc_pkg::UNITY) : quo;
		want_lo    = (want_raw < NW'(cfg.min_gain)) ? NW'(cfg.min_gain) : want_raw;
		step_a     = (quo == '0) ? NW'(1) : quo;
		step_b     = (step_a > NW'(delta)) ? NW'(delta) : step_a;
		gain_new   = rising ? GW'(cur_q + step_b[GW-1:0]) : GW'(cur_q - step_b[GW-1:0]);
		gain_lo    = (gain_new < cfg.min_gain) ? cfg.min_gain : gain_new;
		safe_hi    = (quo > NW'(cfg.max_gain)) ? NW'(cfg.max_gain) : quo;
		safe_lo    = (safe_hi < NW'(cfg.min_gain)) ? NW'(cfg.min_gain) : safe_hi;
		app_a      = ((peak_q != '0) && (NW'(cur_q) > safe_lo)) ? safe_lo[GW-1:0] : cur_q;
	end

	assign status.frame_done = frame_end_in || (fill_q + 1'b1 == FW'(MAX_FRAME));
	assign status.div_done   = div_done;
	assign status.emit_last  = (idx_q == fill_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			idx_q     <= '0;
			sum_q     <= '0;
			peak_q    <= '0;
			level_q   <= '0;
			smooth_q  <= fagc_pkg::RST_LEVEL;
			run_q     <= '0;
			want_q    <= fagc_pkg::UNITY;
			cur_q     <= fagc_pkg::UNITY;
			applied_q <= fagc_pkg::UNITY;
		end else begin
			if (cmd.accept) begin
				fill_q <= fill_q + 1'b1;
				sum_q  <= sum_q + fagc_pkg::SUM_W'(abs_in);
				if (abs_in > peak_q) begin
					peak_q <= abs_in;
				end
			end
			if (div_done) begin
				case (cmd.op)
					fagc_pkg::OP_LEVEL: level_q <= quo[GW-1:0];
					fagc_pkg::OP_SMOOTH: begin
						smooth_q <= (smooth_q == '0) ? bounded : quo[GW-1:0];
						if (level_q <= GW'(cfg.silence_level)) begin
							if (run_q < cfg.hang_frames) begin
								run_q <= run_q + 1'b1;
							end
						end else begin
							run_q <= '0;
						end
					end
					fagc_pkg::OP_WANT:
						want_q <= (want_lo > NW'(cfg.max_gain)) ? cfg.max_gain : want_lo[GW-1:0];
					fagc_pkg::OP_STEP:
						cur_q <= (gain_lo > cfg.max_gain) ? cfg.max_gain : gain_lo;
					fagc_pkg::OP_SAFE:
						applied_q <= (app_a > cfg.max_gain) ? cfg.max_gain : app_a;
					default: ;
				endcase
			end
			// advance the readout; drop the frame after its last word
			if (cmd.emit) begin
				if (status.emit_last) begin
					idx_q  <= '0;
					fill_q <= '0;
					sum_q  <= '0;
					peak_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	fagc_ram #(.WIDTH(fagc_pkg::SAMPLE_W), .DEPTH(MAX_FRAME)) u_ram (
		.clk   (clk),
		.we    (cmd.accept),
		.waddr (fill_q[AW-1:0]),
		.wdata (sample_in),
		.re    (cmd.emit),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	fagc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_go),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (quo)
	);

	// scale, round half up, saturate
	assign prod   = $signed(rd_data) * $signed({1'b0, applied_q});
	assign scaled = (prod + (PW'(1) <<< (fagc_pkg::GAIN_FRAC - 1))) >>> fagc_pkg::GAIN_FRAC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			valid_s1     <= cmd.emit;
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		last_s1       <= status.emit_last;
		frame_end_out <= last_s1;
		applied_gain  <= applied_q;
		if (scaled > PW'(32767)) begin
			sample_out <= 16'sh7FFF;
		end else if (scaled < -PW'(32768)) begin
			sample_out <= 16'sh8000;
		end else begin
			sample_out <= scaled[fagc_pkg::SAMPLE_W-1:0];
		end
	end

`ifndef SYNTHESIS
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_end_out |=> !result_valid)
		else $error("word after frame end");
	a_emit_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !div_busy)
		else $error("readout during divide");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(MAX_FRAME))
		else $error("frame overfill");
`endif

endmodule

>>> rtl/fagc_ctrl.sv
// fagc_ctrl: sequencer for capture, the five per-frame divides and the readout.
// Depends on fagc_pkg.
module fagc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  fagc_pkg::status_t   status,
	output fagc_pkg::cmd_t      cmd,
	output logic                busy
);

	fagc_pkg::state_t state_q, state_d;
	fagc_pkg::op_t    op_q, op_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fagc_pkg::ST_IDLE;
			op_q    <= fagc_pkg::OP_LEVEL;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		op_d       = op_q;
		cmd.accept = 1'b0;
		cmd.div_go = 1'b0;
		cmd.emit   = 1'b0;
		cmd.op     = op_q;
		case (state_q)
			fagc_pkg::ST_IDLE: begin
				cmd.accept = start;
				if (start && status.frame_done) begin
					op_d    = fagc_pkg::OP_LEVEL;
					state_d = fagc_pkg::ST_GO;
				end
			end
			fagc_pkg::ST_GO: begin
				cmd.div_go = 1'b1;
				state_d    = fagc_pkg::ST_WAIT;
			end
			fagc_pkg::ST_WAIT: begin
				if (status.div_done) begin
					state_d = fagc_pkg::ST_GO;
					case (op_q)
						fagc_pkg::OP_LEVEL:  op_d = fagc_pkg::OP_SMOOTH;
						fagc_pkg::OP_SMOOTH: op_d = fagc_pkg::OP_WANT;
						fagc_pkg::OP_WANT:   op_d = fagc_pkg::OP_STEP;
						fagc_pkg::OP_STEP:   op_d = fagc_pkg::OP_SAFE;
						default:             state_d = fagc_pkg::ST_EMIT;
					endcase
				end
			end
			fagc_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
				if (status.emit_last) begin
					state_d = fagc_pkg::ST_IDLE;
				end
			end
			default: state_d = fagc_pkg::ST_IDLE;
		endcase
	end

	assign busy = (state_q != fagc_pkg::ST_IDLE);

endmodule
